FILE: design/itl_pkg.sv
// ----------------------------------------------------------------------------
// itl_pkg: shared types and constants for the IDL token lexer
// Token kinds, error codes, lexer modes and the result payload type.
// ----------------------------------------------------------------------------
package itl_pkg;

  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int OFFSET_BITS = 32;
  localparam int LEN_BITS    = 16;
  localparam int VAL_BITS    = 63;
  localparam int KW_MAX      = 9;

  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_INT    = 6'd1;
  localparam logic [5:0] K_DOC    = 6'd2;
  localparam logic [5:0] K_PUNCT0 = 6'd27;
  localparam logic [5:0] K_ARROW  = 6'd39;
  localparam logic [5:0] K_EOF    = 6'd40;
  localparam logic [5:0] K_NONE   = 6'd41;
  localparam logic [5:0] K_VOID   = 6'd42;

  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_CHAR  = 2'd1;
  localparam logic [1:0] E_HEX   = 2'd2;
  localparam logic [1:0] E_RANGE = 2'd3;

  typedef enum logic [11:0] {
    M_START   = 12'b000000000001,
    M_IDENT   = 12'b000000000010,
    M_ZERO    = 12'b000000000100,
    M_DEC     = 12'b000000001000,
    M_HEXPRE  = 12'b000000010000,
    M_HEX     = 12'b000000100000,
    M_SLASH1  = 12'b000001000000,
    M_SLASH2  = 12'b000010000000,
    M_COMMENT = 12'b000100000000,
    M_DOCSP   = 12'b001000000000,
    M_DOC     = 12'b010000000000,
    M_DASH    = 12'b100000000000
  } mode_t;

  typedef struct packed {
    logic [5:0]             token_kind;
    logic [1:0]             error_code;
    logic [LINE_BITS-1:0]   origin_line;
    logic [COLUMN_BITS-1:0] origin_column;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LEN_BITS-1:0]    text_length;
    logic [VAL_BITS-1:0]    integer_value;
    logic                   last_of_run;
  } tok_t;

  // Keyword lookup on a zero-padded 9-byte window (byte 0 in the low bits).
  function automatic logic [5:0] kw_kind(input logic [71:0] w, input logic [LEN_BITS-1:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case (n)
      16'd2: begin
        if (w[15:0] == "8i") k = 6'd15;
        if (w[15:0] == "8u") k = 6'd19;
      end
      16'd3: begin
        case (w[23:0])
          "61i": k = 6'd16;
          "23i": k = 6'd17;
          "46i": k = 6'd18;
          "61u": k = 6'd20;
          "23u": k = 6'd21;
          "46u": k = 6'd22;
          "23f": k = 6'd23;
          "46f": k = 6'd24;
          default: k = K_IDENT;
        endcase
      end
      16'd4: begin
        case (w[31:0])
          "mune": k = 6'd6;
          "loob": k = 6'd14;
          "diov": k = K_VOID;
          default: k = K_IDENT;
        endcase
      end
      16'd5: begin
        case (w[39:0])
          "ssalc": k = 6'd5;
          "sgalf": k = 6'd7;
          "rorre": k = 6'd9;
          "setyb": k = 6'd26;
          default: k = K_IDENT;
        endcase
      end
      16'd6: begin
        case (w[47:0])
          "tcurts": k = 6'd4;
          "maerts": k = 6'd12;
          "sworht": k = 6'd13;
          "gnirts": k = 6'd25;
          default: k = K_IDENT;
        endcase
      end
      16'd7: if (w[55:0] == "ecivres") k = 6'd8;
      16'd8: begin
        if (w[63:0] == "ylnodaer") k = 6'd10;
        if (w[63:0] == "lanoitpo") k = 6'd11;
      end
      16'd9: if (w == "ecapseman") k = 6'd3;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

FILE: design/itl_stream_if.sv
// ----------------------------------------------------------------------------
// itl_in_if / itl_out_if: valid/ready channels of the lexer
// Input bytes and result tokens.
// ----------------------------------------------------------------------------
interface itl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;
  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface itl_out_if import itl_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [5:0]             token_kind;
  logic [1:0]             error_code;
  logic [LINE_BITS-1:0]   origin_line;
  logic [COLUMN_BITS-1:0] origin_column;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LEN_BITS-1:0]    text_length;
  logic [VAL_BITS-1:0]    integer_value;
  logic                   last_of_run;
  modport source (output valid, output token_kind, output error_code, output origin_line,
                  output origin_column, output start_offset, output text_length,
                  output integer_value, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input error_code, input origin_line,
                  input origin_column, input start_offset, input text_length,
                  input integer_value, input last_of_run, output ready);
endinterface

FILE: design/idl_token_lexer_core.sv
// ----------------------------------------------------------------------------
// idl_token_lexer_core: streaming tokenizer for a small IDL
// Turns a byte stream into tokens with position, length and integer value.
// ----------------------------------------------------------------------------
// Usage: source bytes enter on in_ch, one item per byte, with final_byte set
// on the last byte of a text. Tokens leave on out_ch; each byte causes zero,
// one or two tokens, and last_of_run marks the final token of a byte.
// One byte is taken per clock while the queue has room. The byte is decoded in the accept cycle and
// its tokens are written into a three-entry result queue; the first token is
// visible on the next cycle if the queue was empty. The queue drains one token per
// cycle while out_ch is ready, so input is refused only while fewer than two queue slots are free:
// a byte can yield two tokens.
// When the final byte closes one token, makes another and ends the text, the
// end-of-file token is held owed; the next byte only releases it and is
// otherwise ignored.
// After an error all bytes up to the final one are discarded.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to
// line 1, column 1, offset 0. When out_ch stalls, tokens wait in the queue
// and in_ch ready drops once the queue cannot take two more.
// ----------------------------------------------------------------------------
module idl_token_lexer_core import itl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  itl_in_if.sink       in_ch,
  itl_out_if.source    out_ch
);

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LEN_BITS-1:0]    LEN_MAX  = '1;
  localparam logic [VAL_BITS-1:0]    INT_MAX  = '1;

  // Lexer state.
  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, tline_r, tline_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, tcol_r, tcol_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, toff_r, toff_nxt;
  logic [LEN_BITS-1:0]    tlen_r, tlen_nxt;
  logic [71:0]            kw_r, kw_nxt;
  logic [VAL_BITS-1:0]    acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   disc_r, disc_nxt;
  logic                   owed_r, owed_nxt;
  tok_t                   owed_tok_r, owed_tok_nxt;

  // Result queue.
  tok_t       q_r [3];
  logic [1:0] qcnt_r;
  logic [1:0] qhead_r;

  tok_t   res [3];
  logic [1:0] nres;
  logic   errd;
  logic   in_acc, out_acc;
  logic [7:0] b;
  logic   fin;

  assign b       = in_ch.text_byte;
  assign fin     = in_ch.final_byte;
  assign in_ch.ready = (qcnt_r <= 2'd1);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (is_dig(c)) t = c - 8'd48;
    else if (c >= "a" && c <= "f") t = c - 8'd87;
    else t = c - 8'd55;
    return t[3:0];
  endfunction
  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] l);
    return (l != LEN_MAX) ? l + 1'b1 : l;
  endfunction
  function automatic logic [4:0] punct_idx(input logic [7:0] c);
    logic [4:0] p;
    case (c)
      ";": p = 5'd0;   ",": p = 5'd1;   ":": p = 5'd2;   ".": p = 5'd3;
      "{": p = 5'd4;   "}": p = 5'd5;   "(": p = 5'd6;   ")": p = 5'd7;
      "[": p = 5'd8;   "]": p = 5'd9;   "?": p = 5'd10;  "=": p = 5'd11;
      default: p = 5'd31;
    endcase
    return p;
  endfunction

  always_comb begin
    logic [4:0]            pi;
    logic                  acc_en, ovf_hit;
    logic [3:0]            dig;
    logic                  hexb, restart;
    logic [VAL_BITS+3:0]   prod;
    tok_t                  t;
    logic [5:0]            kk;
    mode_nxt = mode_r;
    line_nxt = line_r; col_nxt = col_r; off_nxt = off_r;
    tline_nxt = tline_r; tcol_nxt = tcol_r; toff_nxt = toff_r; tlen_nxt = tlen_r;
    kw_nxt = kw_r; acc_nxt = acc_r; ovf_nxt = ovf_r; disc_nxt = disc_r;
    owed_nxt = owed_r; owed_tok_nxt = owed_tok_r;
    for (int i = 0; i < 3; i++) res[i] = '0;
    nres = 2'd0; errd = 1'b0;
    restart = 1'b0; acc_en = 1'b0; hexb = 1'b0; dig = '0; ovf_hit = 1'b0;
    prod = '0; kk = K_IDENT; t = '0;
    pi = punct_idx(b);

    if (in_acc) begin
      if (owed_r) begin
        owed_nxt = 1'b0;
        res[0] = owed_tok_r; nres = 2'd1;
      end else if (disc_r) begin
        if (fin) restart = 1'b1;
      end else begin
        // Token close step for the byte.
        unique case (mode_r)
          M_IDENT: begin
            if (is_alpha(b) || is_dig(b) || b == "_") begin
              for (int i = 0; i < KW_MAX; i++)
                if (tlen_r == LEN_BITS'(i)) kw_nxt[8*i +: 8] = b;
              tlen_nxt = len_inc(tlen_r);
            end else begin
              kk = (tlen_r <= LEN_BITS'(KW_MAX)) ? kw_kind(kw_r, tlen_r) : K_IDENT;
              t = '0; t.token_kind = kk; t.origin_line = tline_r; t.origin_column = tcol_r;
              t.start_offset = toff_r; t.text_length = tlen_r;
              res[nres] = t; nres = nres + 2'd1;
              mode_nxt = M_START;
            end
          end
          M_ZERO, M_DEC, M_HEX: begin
            hexb = (mode_r == M_HEX);
            if (mode_r == M_ZERO && (b == "x" || b == "X")) begin
              tlen_nxt = len_inc(tlen_r); mode_nxt = M_HEXPRE;
            end else if ((hexb && is_hex(b)) || (!hexb && is_dig(b))) begin
              acc_en = 1'b1; dig = hex_val(b);
              if (mode_r == M_ZERO) mode_nxt = M_DEC;
            end else begin
              t = '0; t.origin_line = tline_r; t.origin_column = tcol_r;
              t.start_offset = toff_r;
              if (ovf_r) begin
                t.token_kind = K_NONE; t.error_code = E_RANGE; errd = 1'b1;
              end else begin
                t.token_kind = K_INT; t.text_length = tlen_r; t.integer_value = acc_r;
              end
              res[nres] = t; nres = nres + 2'd1;
              mode_nxt = M_START;
            end
          end
          M_HEXPRE: begin
            if (is_hex(b)) begin
              acc_en = 1'b1; hexb = 1'b1; dig = hex_val(b); mode_nxt = M_HEX;
            end else begin
              t = '0; t.token_kind = K_NONE; t.error_code = E_HEX;
              t.origin_line = tline_r; t.origin_column = tcol_r; t.start_offset = toff_r;
              res[nres] = t; nres = nres + 2'd1; errd = 1'b1;
            end
          end
          M_SLASH1, M_DASH: begin
            if (mode_r == M_SLASH1 && b == "/") begin
              tlen_nxt = len_inc(tlen_r); mode_nxt = M_SLASH2;
            end else if (mode_r == M_DASH && b == ">") begin
              t = '0; t.token_kind = K_ARROW; t.origin_line = tline_r;
              t.origin_column = tcol_r; t.start_offset = toff_r; t.text_length = 16'd2;
              tlen_nxt = 16'd2;
              res[nres] = t; nres = nres + 2'd1; mode_nxt = M_START;
            end else begin
              t = '0; t.token_kind = K_NONE; t.error_code = E_CHAR;
              t.origin_line = tline_r; t.origin_column = tcol_r; t.start_offset = toff_r;
              res[nres] = t; nres = nres + 2'd1; errd = 1'b1;
            end
          end
          M_SLASH2: mode_nxt = (b == "/") ? M_DOCSP : (b == 8'h0A) ? M_START : M_COMMENT;
          M_COMMENT: if (b == 8'h0A) mode_nxt = M_START;
          M_DOCSP: begin
            tlen_nxt = '0;
            if (b == " ") begin
              toff_nxt = off_r + 1'b1; mode_nxt = M_DOC;
            end else if (b == 8'h0A) begin
              toff_nxt = off_r;
              t = '0; t.token_kind = K_DOC; t.origin_line = tline_r; t.origin_column = tcol_r;
              t.start_offset = off_r;
              res[nres] = t; nres = nres + 2'd1; mode_nxt = M_START;
            end else begin
              toff_nxt = off_r; tlen_nxt = 16'd1; mode_nxt = M_DOC;
            end
          end
          M_DOC: begin
            if (b == 8'h0A) begin
              t = '0; t.token_kind = K_DOC; t.origin_line = tline_r; t.origin_column = tcol_r;
              t.start_offset = toff_r; t.text_length = tlen_r;
              res[nres] = t; nres = nres + 2'd1; mode_nxt = M_START;
            end else tlen_nxt = len_inc(tlen_r);
          end
          M_START: mode_nxt = M_START;
          default: mode_nxt = M_START;
        endcase

        // Decimal/hex accumulate with overflow check.
        if (acc_en) begin
          prod = hexb ? {acc_r, 4'b0} : ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1);
          prod = prod + (VAL_BITS + 4)'(dig);
          ovf_hit = prod > {4'b0, INT_MAX};
          if (!ovf_r && ovf_hit) ovf_nxt = 1'b1;
          if (!ovf_r && !ovf_hit) acc_nxt = prod[VAL_BITS-1:0];
          tlen_nxt = len_inc(tlen_r);
        end

        // Start-of-token step, when the closing step returned to start.
        if (!errd && mode_nxt == M_START &&
            (mode_r == M_START || mode_r == M_IDENT || mode_r == M_ZERO ||
             mode_r == M_DEC || mode_r == M_HEX)) begin
          if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
            mode_nxt = M_START;
          end else if (pi != 5'd31) begin
            tline_nxt = line_r; tcol_nxt = col_r; toff_nxt = off_r; tlen_nxt = 16'd1;
            t = '0; t.token_kind = K_PUNCT0 + {1'b0, pi}; t.origin_line = line_r;
            t.origin_column = col_r; t.start_offset = off_r; t.text_length = 16'd1;
            res[nres] = t; nres = nres + 2'd1;
          end else if (b == "/" || b == "-" || is_dig(b) || is_alpha(b) || b == "_") begin
            tline_nxt = line_r; tcol_nxt = col_r; toff_nxt = off_r; tlen_nxt = 16'd1;
            if (b == "/") mode_nxt = M_SLASH1;
            else if (b == "-") mode_nxt = M_DASH;
            else if (is_dig(b)) begin
              acc_nxt = VAL_BITS'(hex_val(b)); ovf_nxt = 1'b0;
              mode_nxt = (b == "0") ? M_ZERO : M_DEC;
            end else begin
              kw_nxt = {64'b0, b}; mode_nxt = M_IDENT;
            end
          end else begin
            t = '0; t.token_kind = K_NONE; t.error_code = E_CHAR; t.origin_line = line_r;
            t.origin_column = col_r; t.start_offset = off_r;
            res[nres] = t; nres = nres + 2'd1; errd = 1'b1;
          end
        end

        // Advance position.
        off_nxt = off_r + 1'b1;
        if (b == 8'h0A) begin
          line_nxt = (line_r != LINE_MAX) ? line_r + 1'b1 : line_r;
          col_nxt = COLUMN_BITS'(1);
        end else col_nxt = (col_r != COL_MAX) ? col_r + 1'b1 : col_r;

        if (fin) begin
          if (!errd) begin
            t = '0; t.origin_line = tline_nxt; t.origin_column = tcol_nxt;
            t.start_offset = toff_nxt; t.text_length = tlen_nxt;
            case (mode_nxt)
              M_IDENT: begin
                t.token_kind = (tlen_nxt <= LEN_BITS'(KW_MAX)) ?
                               kw_kind(kw_nxt, tlen_nxt) : K_IDENT;
                res[nres] = t; nres = nres + 2'd1;
              end
              M_ZERO, M_DEC, M_HEX: begin
                if (ovf_nxt) begin
                  t.token_kind = K_NONE; t.error_code = E_RANGE; t.text_length = '0;
                  errd = 1'b1;
                end else begin
                  t.token_kind = K_INT; t.integer_value = acc_nxt;
                end
                res[nres] = t; nres = nres + 2'd1;
              end
              M_HEXPRE, M_SLASH1, M_DASH: begin
                t.token_kind = K_NONE; t.text_length = '0;
                t.error_code = (mode_nxt == M_HEXPRE) ? E_HEX : E_CHAR;
                res[nres] = t; nres = nres + 2'd1; errd = 1'b1;
              end
              M_DOCSP: begin
                // An empty doc comment at the end of text sits after the last byte.
                t.token_kind = K_DOC; t.start_offset = off_nxt; t.text_length = '0;
                res[nres] = t; nres = nres + 2'd1;
              end
              M_DOC: begin
                t.token_kind = K_DOC;
                res[nres] = t; nres = nres + 2'd1;
              end
              default: ;
            endcase
            if (!errd) begin
              t = '0; t.token_kind = K_EOF; t.origin_line = line_nxt;
              t.origin_column = col_nxt; t.start_offset = off_nxt;
              if (nres == 2'd2) begin
                owed_nxt = 1'b1; owed_tok_nxt = t; owed_tok_nxt.last_of_run = 1'b1;
              end else begin
                res[nres] = t; nres = nres + 2'd1;
              end
            end
          end
          restart = 1'b1;
        end else if (errd) begin
          disc_nxt = 1'b1; mode_nxt = M_START;
        end
        if (nres != 2'd0 && !owed_nxt) res[nres - 2'd1].last_of_run = 1'b1;
      end

      if (restart) begin
        mode_nxt = M_START;
        line_nxt = LINE_BITS'(1); col_nxt = COLUMN_BITS'(1); off_nxt = '0;
        tline_nxt = LINE_BITS'(1); tcol_nxt = COLUMN_BITS'(1); toff_nxt = '0;
        tlen_nxt = '0; kw_nxt = '0; acc_nxt = '0; ovf_nxt = 1'b0; disc_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      line_r <= LINE_BITS'(1); col_r <= COLUMN_BITS'(1); off_r <= '0;
      tline_r <= LINE_BITS'(1); tcol_r <= COLUMN_BITS'(1); toff_r <= '0;
      tlen_r <= '0; kw_r <= '0; acc_r <= '0; ovf_r <= 1'b0; disc_r <= 1'b0;
      owed_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      line_r <= line_nxt; col_r <= col_nxt; off_r <= off_nxt;
      tline_r <= tline_nxt; tcol_r <= tcol_nxt; toff_r <= toff_nxt;
      tlen_r <= tlen_nxt; kw_r <= kw_nxt; acc_r <= acc_nxt; ovf_r <= ovf_nxt;
      disc_r <= disc_nxt; owed_r <= owed_nxt;
    end
    owed_tok_r <= owed_tok_nxt;
  end

  // Three-entry circular result queue; writes land behind the current tail.
  logic [1:0] qcnt_after;
  assign qcnt_after = qcnt_r - {1'b0, out_acc};

  always_ff @(posedge clk) begin
    logic [2:0] w;
    if (!rst_n) begin
      qcnt_r <= '0; qhead_r <= '0;
    end else begin
      qhead_r <= out_acc ? ((qhead_r == 2'd2) ? 2'd0 : qhead_r + 2'd1) : qhead_r;
      qcnt_r  <= qcnt_after + nres;
    end
    for (int i = 0; i < 2; i++) begin
      w = {1'b0, qhead_r} + {1'b0, qcnt_r} + 3'(i);
      if (w >= 3'd3) w = w - 3'd3;
      if (2'(i) < nres) q_r[w[1:0]] <= res[i];
    end
  end

  tok_t head;
  assign head = q_r[qhead_r];
  assign out_ch.valid         = (qcnt_r != 2'd0);
  assign out_ch.token_kind    = head.token_kind;
  assign out_ch.error_code    = head.error_code;
  assign out_ch.origin_line   = head.origin_line;
  assign out_ch.origin_column = head.origin_column;
  assign out_ch.start_offset  = head.start_offset;
  assign out_ch.text_length   = head.text_length;
  assign out_ch.integer_value = head.integer_value;
  assign out_ch.last_of_run   = head.last_of_run;

  // The queue never holds more than its three slots.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, qcnt_after} + {1'b0, nres} <= 3'd3) else $error("result queue overfilled");
  // Input is refused whenever two more results could not fit.
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r >= 2'd2 |-> !in_ch.ready) else $error("input taken with queue nearly full");
  // An owed end-of-file token is released by the very next accepted byte.
  a_owed_release: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r && in_acc |=> !owed_r) else $error("owed token not released");
  // The discard state never holds while a token is owed.
  a_owed_disc: assert property (@(posedge clk) disable iff (!rst_n)
    !(owed_r && disc_r)) else $error("owed token during discard");

endmodule
